@@ hw/rtl/owbm_pkg.sv @@
package owbm_pkg;

  // field widths
  localparam int unsigned TickW    = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegResetLowTime = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPresenceWait = 3'd1;
  localparam logic [CfgIdxW-1:0] RegResetTail    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegShortLowTime = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSlotRestTime = 3'd4;
  localparam logic [CfgIdxW-1:0] RegZeroLowTime  = 3'd5;

  // register reset values
  localparam logic [9:0] ResetLowTimeDef = 10'd480;
  localparam logic [7:0] PresenceWaitDef = 8'd80;
  localparam logic [9:0] ResetTailDef    = 10'd400;
  localparam logic [3:0] ShortLowTimeDef = 4'd1;
  localparam logic [7:0] SlotRestTimeDef = 8'd50;
  localparam logic [7:0] ZeroLowTimeDef  = 8'd50;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RST_LOW   = 3'd1,
    PH_RST_WAIT  = 3'd2,
    PH_RST_TAIL  = 3'd3,
    PH_SLOT_LOW  = 3'd4,
    PH_SLOT_REST = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_kind_e;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [7:0] presence_wait;
    logic [9:0] reset_tail;
    logic [3:0] short_low_time;
    logic [7:0] slot_rest_time;
    logic [7:0] zero_low_time;
  } cfg_t;

  typedef struct packed {
    op_kind_e   action;
    logic [7:0] data_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       presence_found;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } res_item_t;

endpackage

@@ hw/rtl/owbm_cfg_regs.sv @@
module owbm_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [owbm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [owbm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output owbm_pkg::cfg_t                 cfg_o
);

  owbm_pkg::cfg_t cfg_q, cfg_d;

  // decode one write into the register set
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        owbm_pkg::RegResetLowTime: cfg_d.reset_low_time = cfg_wdata_i[9:0];
        owbm_pkg::RegPresenceWait: cfg_d.presence_wait  = cfg_wdata_i[7:0];
        owbm_pkg::RegResetTail:    cfg_d.reset_tail     = cfg_wdata_i[9:0];
        owbm_pkg::RegShortLowTime: cfg_d.short_low_time = cfg_wdata_i[3:0];
        owbm_pkg::RegSlotRestTime: cfg_d.slot_rest_time = cfg_wdata_i[7:0];
        owbm_pkg::RegZeroLowTime:  cfg_d.zero_low_time  = cfg_wdata_i[7:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time <= owbm_pkg::ResetLowTimeDef;
      cfg_q.presence_wait  <= owbm_pkg::PresenceWaitDef;
      cfg_q.reset_tail     <= owbm_pkg::ResetTailDef;
      cfg_q.short_low_time <= owbm_pkg::ShortLowTimeDef;
      cfg_q.slot_rest_time <= owbm_pkg::SlotRestTimeDef;
      cfg_q.zero_low_time  <= owbm_pkg::ZeroLowTimeDef;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/owbm_core.sv @@
module owbm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  owbm_pkg::in_item_t  item_i,
  input  owbm_pkg::cfg_t      cfg_i,
  output owbm_pkg::res_item_t res_o
);

  owbm_pkg::phase_e   phase_q, phase_d, ph_start;
  owbm_pkg::op_kind_e op_q, op_d, op_start;
  logic [owbm_pkg::TickW-1:0] tc_q, tc_d, tc_start;
  logic [2:0] bit_q, bit_d, bit_start;
  logic [7:0] shift_q, shift_d, shift_start;
  logic       presence_q, presence_d;
  logic [7:0] read_q, read_d;

  logic [owbm_pkg::TickW:0] tc_inc;
  logic [owbm_pkg::TickW:0] len;
  logic [owbm_pkg::TickW:0] rst_low_len, wait_len, tail_len;
  logic [owbm_pkg::TickW:0] short_len, zero_len, rest_len;
  logic       send_zero;
  logic       drive, busy, done;

  // command load while idle
  always_comb begin
    ph_start    = phase_q;
    op_start    = op_q;
    tc_start    = tc_q;
    bit_start   = bit_q;
    shift_start = shift_q;
    if (phase_q == owbm_pkg::PH_IDLE && item_i.action != owbm_pkg::OP_NONE) begin
      op_start    = item_i.action;
      tc_start    = '0;
      bit_start   = '0;
      shift_start = (item_i.action == owbm_pkg::OP_WRITE) ? item_i.data_byte : 8'd0;
      ph_start    = (item_i.action == owbm_pkg::OP_RESET) ? owbm_pkg::PH_RST_LOW
                                                          : owbm_pkg::PH_SLOT_LOW;
    end
  end

  // phase lengths, a zero length counts as one tick, but a zero reset tail skips the tail phase
  assign rst_low_len = (cfg_i.reset_low_time == '0) ? 11'd1 : {1'b0, cfg_i.reset_low_time};
  assign wait_len    = (cfg_i.presence_wait == '0) ? 11'd1 : {3'b0, cfg_i.presence_wait};
  assign tail_len    = {1'b0, cfg_i.reset_tail};
  assign short_len   = (cfg_i.short_low_time == '0) ? 11'd1 : {7'b0, cfg_i.short_low_time};
  assign zero_len    = (cfg_i.zero_low_time == '0) ? 11'd1 : {3'b0, cfg_i.zero_low_time};
  assign rest_len    = (cfg_i.slot_rest_time == '0) ? 11'd1 : {3'b0, cfg_i.slot_rest_time};

  assign send_zero = (op_start == owbm_pkg::OP_WRITE) && !shift_start[0];
  assign tc_inc    = {1'b0, tc_start} + 11'd1;

  // one tick of the bus sequencer
  always_comb begin
    phase_d    = ph_start;
    op_d       = op_start;
    tc_d       = tc_start;
    bit_d      = bit_start;
    shift_d    = shift_start;
    presence_d = presence_q;
    read_d     = read_q;
    drive      = 1'b0;
    busy       = 1'b0;
    done       = 1'b0;
    len        = '0;
    case (ph_start)
      owbm_pkg::PH_RST_LOW: begin
        busy = 1'b1;
        drive = 1'b1;
        tc_d = tc_inc[owbm_pkg::TickW-1:0];
        if (tc_inc >= rst_low_len) begin
          phase_d = owbm_pkg::PH_RST_WAIT;
          tc_d = '0;
        end
      end
      owbm_pkg::PH_RST_WAIT: begin
        busy = 1'b1;
        tc_d = tc_inc[owbm_pkg::TickW-1:0];
        if (tc_inc >= wait_len) begin
          presence_d = !item_i.line_level;
          tc_d = '0;
          if (cfg_i.reset_tail == '0) begin
            phase_d = owbm_pkg::PH_IDLE;
            done = 1'b1;
          end else begin
            phase_d = owbm_pkg::PH_RST_TAIL;
          end
        end
      end
      owbm_pkg::PH_RST_TAIL: begin
        busy = 1'b1;
        tc_d = tc_inc[owbm_pkg::TickW-1:0];
        if (tc_inc >= tail_len) begin
          phase_d = owbm_pkg::PH_IDLE;
          tc_d = '0;
          done = 1'b1;
        end
      end
      owbm_pkg::PH_SLOT_LOW: begin
        busy = 1'b1;
        drive = 1'b1;
        len = send_zero ? zero_len : short_len;
        tc_d = tc_inc[owbm_pkg::TickW-1:0];
        if (tc_inc >= len) begin
          phase_d = owbm_pkg::PH_SLOT_REST;
          tc_d = '0;
        end
      end
      owbm_pkg::PH_SLOT_REST: begin
        busy = 1'b1;
        // read sample on the first released tick of the slot
        if (op_start == owbm_pkg::OP_READ && tc_start == '0) begin
          shift_d[bit_start] = shift_start[bit_start] | item_i.line_level;
        end
        len = send_zero ? 11'd1 : rest_len;
        tc_d = tc_inc[owbm_pkg::TickW-1:0];
        if (tc_inc >= len) begin
          tc_d = '0;
          if (op_start == owbm_pkg::OP_WRITE) begin
            shift_d = {1'b0, shift_start[7:1]};
          end
          if (bit_start == 3'd7) begin
            if (op_start == owbm_pkg::OP_READ) begin
              read_d = shift_d;
            end
            phase_d = owbm_pkg::PH_IDLE;
            done = 1'b1;
          end else begin
            bit_d = bit_start + 3'd1;
            phase_d = owbm_pkg::PH_SLOT_LOW;
          end
        end
      end
      default: begin
        phase_d = owbm_pkg::PH_IDLE;
      end
    endcase
  end

  // sequencer state advances once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= owbm_pkg::PH_IDLE;
      op_q       <= owbm_pkg::OP_NONE;
      tc_q       <= '0;
      bit_q      <= '0;
      shift_q    <= '0;
      presence_q <= 1'b0;
      read_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      op_q       <= op_d;
      tc_q       <= tc_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      presence_q <= presence_d;
      read_q     <= read_d;
    end
  end

  assign res_o.drive_low      = drive;
  assign res_o.busy_res       = busy;
  assign res_o.done_res       = done;
  assign res_o.presence_found = presence_d;
  assign res_o.read_data      = read_d;

endmodule

@@ hw/rtl/onewire_bus_master_unit.sv @@
// 1-Wire bus master driven by one item per microsecond tick. Every item yields
// exactly one result item; one item can be taken every clock cycle unless
// m_axis_tready stalls the result. An item passes the input register, then the
// result register. The sequencer state loop in the core sets the rate and finishes
// one tick per unstalled cycle. An item may carry a command (reset, write byte, read
// byte) that starts while the block is idle; commands during an operation are
// ignored. The user must write timing registers through the configuration port only
// while no item is in flight; the block does not enforce this.
module onewire_bus_master_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [owbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [owbm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // data_byte[7:0], line_level[8]
  input  logic [1:0]                    s_axis_tuser,  // action[1:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata   // drive_low[0], busy_res[1],
                                                       // done_res[2], presence_found[3],
                                                       // read_data[11:4]
);

  owbm_pkg::cfg_t      cfg;
  owbm_pkg::in_item_t  in_q;
  owbm_pkg::res_item_t res, res_q;
  logic in_valid_q, out_valid_q;
  logic advance, step;

  // pipeline flow control
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  owbm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.action     <= owbm_pkg::op_kind_e'(s_axis_tuser);
      in_q.data_byte  <= s_axis_tdata[7:0];
      in_q.line_level <= s_axis_tdata[8];
    end
  end

  owbm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, res_q};

endmodule
